@@ rtl/protobuf_top_field_locator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Field locator assertion macros
// Shared assertion forms; each expects clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_TOP_FIELD_LOCATOR_TOP_MACROS_SVH
`define PROTOBUF_TOP_FIELD_LOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define PFL_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pfl_pkg.sv @@
// ----------------------------------------------------------------------------
// Field locator package
// Types and constants shared by the protobuf top-level field locator.
// ----------------------------------------------------------------------------
package pfl_pkg;

    localparam int MAX_BUFFER_BYTES = 65536;
    localparam int IDX_W            = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int SKIP_W           = IDX_W;
    localparam int DATA_W           = 8;
    localparam int POS_W            = 16;
    localparam int FIELD_W          = 29;
    localparam int WIRE_W           = 3;
    localparam int ACC_W            = FIELD_W + WIRE_W;
    localparam int GROUP_W          = 4;

    localparam logic [FIELD_W-1:0] WANTED_RESET = FIELD_W'(3);

    // Number of 7-bit groups that still land inside a 64-bit varint.
    localparam logic [GROUP_W-1:0] GROUP_LIMIT = GROUP_W'(10);

    localparam logic [WIRE_W-1:0] WIRE_VARINT  = WIRE_W'(0);
    localparam logic [WIRE_W-1:0] WIRE_FIXED64 = WIRE_W'(1);
    localparam logic [WIRE_W-1:0] WIRE_LEN     = WIRE_W'(2);
    localparam logic [WIRE_W-1:0] WIRE_FIXED32 = WIRE_W'(5);

    localparam logic [SKIP_W-1:0] SKIP_FIXED32 = SKIP_W'(4);
    localparam logic [SKIP_W-1:0] SKIP_FIXED64 = SKIP_W'(8);
    localparam logic [IDX_W-1:0]  IDX_LIMIT    = IDX_W'(MAX_BUFFER_BYTES);

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VALUE,
        PH_LEN,
        PH_SKIP,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  value_position;
        logic [DATA_W-1:0] value_first_byte;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } result_beat_t;

endpackage

@@ rtl/pfl_byte_if.sv @@
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one byte of the encoded buffer per beat.
// ----------------------------------------------------------------------------
interface pfl_byte_if;
    import pfl_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/pfl_result_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one locate result per beat.
// ----------------------------------------------------------------------------
interface pfl_result_if;
    import pfl_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [POS_W-1:0]  value_position;
    logic [DATA_W-1:0] value_first_byte;

    modport source (output valid, output found, output value_position,
                    output value_first_byte, input ready);
    modport sink   (input valid, input found, input value_position,
                    input value_first_byte, output ready);
endinterface

@@ rtl/pfl_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the wanted field number.
// ----------------------------------------------------------------------------
interface pfl_cfg_if;
    import pfl_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] wanted_field;

    modport source (output valid, output wanted_field, input ready);
    modport sink   (input valid, input wanted_field, output ready);
endinterface

@@ rtl/pfl_in_stage.sv @@
// ----------------------------------------------------------------------------
// Field locator input register
// Holds one incoming byte beat until the scanner consumes it.
// ----------------------------------------------------------------------------
module pfl_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    pfl_byte_if.sink      bytes,
    input  logic          advance,
    output logic          item_valid,
    output pfl_pkg::item_t item
);
    import pfl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign bytes.ready = !valid_reg || advance;
    assign take        = bytes.valid && bytes.ready;
    assign valid_next  = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte <= bytes.data_byte;
            item_reg.last_byte <= bytes.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

@@ rtl/pfl_scan.sv @@
// ----------------------------------------------------------------------------
// Field locator scanner
// Per-byte wire-format state update and the wanted field register.
// ----------------------------------------------------------------------------
`include "protobuf_top_field_locator_top_macros.svh"

module pfl_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    pfl_cfg_if.sink               cfg,
    input  logic                  advance,
    input  pfl_pkg::item_t        item,
    output pfl_pkg::result_beat_t beat
);
    import pfl_pkg::*;

    logic [FIELD_W-1:0] wanted_reg;
    phase_t             phase_reg,       phase_next;
    logic [ACC_W-1:0]   acc_reg,         acc_next;
    logic               acc_hi_reg,      acc_hi_next;
    logic [GROUP_W-1:0] group_reg,       group_next;
    logic [SKIP_W-1:0]  skip_reg,        skip_next;
    logic [IDX_W-1:0]   byte_index_reg,  byte_index_next;
    logic [IDX_W-1:0]   value_start_reg, value_start_next;
    logic [DATA_W-1:0]  start_byte_reg,  start_byte_next;
    logic               match_reg,       match_next;
    logic               decided_reg,     decided_next;

    logic [DATA_W-1:0]  b;
    logic               is_end;
    logic [ACC_W-1:0]   acc_add;
    logic               hi_add;
    logic [ACC_W-1:0]   acc_sum;
    logic               hi_sum;
    logic [GROUP_W-1:0] group_inc;
    phase_t             ph;
    logic               at_start;
    logic [DATA_W-1:0]  first_byte;

    assign cfg.ready = 1'b1;

    assign b         = item.data_byte;
    assign is_end    = !b[7];
    assign at_start  = (byte_index_reg == value_start_reg);
    assign first_byte = at_start ? b : start_byte_reg;
    assign group_inc = (group_reg < GROUP_LIMIT) ? group_reg + GROUP_W'(1) : group_reg;

    // Place the 7 payload bits of this varint byte. Only the low 32 key bits are kept;
    // anything landing in bits 32..63 just sets the high-nonzero flag.
    always_comb
    begin
        acc_add = '0;
        hi_add  = 1'b0;
        case (group_reg)
            4'd0:    acc_add = {25'd0, b[6:0]};
            4'd1:    acc_add = {18'd0, b[6:0], 7'd0};
            4'd2:    acc_add = {11'd0, b[6:0], 14'd0};
            4'd3:    acc_add = {4'd0, b[6:0], 21'd0};
            4'd4:
            begin
                acc_add = {b[3:0], 28'd0};
                hi_add  = |b[6:4];
            end
            4'd5, 4'd6, 4'd7, 4'd8: hi_add = |b[6:0];
            4'd9:    hi_add = b[0];
            default: hi_add = 1'b0;
        endcase
    end

    assign acc_sum = acc_reg | acc_add;
    assign hi_sum  = acc_hi_reg | hi_add;

    always_comb
    begin
        phase_next       = phase_reg;
        acc_next         = acc_reg;
        acc_hi_next      = acc_hi_reg;
        group_next       = group_reg;
        skip_next        = skip_reg;
        byte_index_next  = byte_index_reg;
        value_start_next = value_start_reg;
        start_byte_next  = start_byte_reg;
        match_next       = match_reg;
        decided_next     = decided_reg;
        beat             = '0;
        ph               = (byte_index_reg >= IDX_LIMIT) ? PH_STOP : phase_reg;

        if (!decided_reg)
        begin
            phase_next = ph;
            case (ph)
                PH_TAG:
                begin
                    acc_next    = acc_sum;
                    acc_hi_next = hi_sum;
                    group_next  = group_inc;
                    if (is_end)
                    begin
                        acc_next    = '0;
                        acc_hi_next = 1'b0;
                        group_next  = '0;
                        case (acc_sum[WIRE_W-1:0])
                            WIRE_VARINT:
                            begin
                                match_next = !hi_sum && (acc_sum[ACC_W-1:WIRE_W] == wanted_reg);
                                value_start_next = byte_index_reg + IDX_W'(1);
                                phase_next = PH_VALUE;
                            end
                            WIRE_LEN:
                            begin
                                phase_next = PH_LEN;
                            end
                            WIRE_FIXED32:
                            begin
                                skip_next  = SKIP_FIXED32;
                                phase_next = PH_SKIP;
                            end
                            WIRE_FIXED64:
                            begin
                                skip_next  = SKIP_FIXED64;
                                phase_next = PH_SKIP;
                            end
                            default:
                            begin
                                phase_next = PH_STOP;
                            end
                        endcase
                    end
                end
                PH_VALUE:
                begin
                    if (at_start)
                    begin
                        start_byte_next = b;
                    end
                    if (is_end)
                    begin
                        if (match_reg)
                        begin
                            beat.valid                = 1'b1;
                            beat.res.found            = 1'b1;
                            beat.res.value_position   = value_start_reg[POS_W-1:0];
                            beat.res.value_first_byte = first_byte;
                            decided_next              = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                end
                PH_LEN:
                begin
                    acc_next    = acc_sum;
                    acc_hi_next = hi_sum;
                    group_next  = group_inc;
                    if (is_end)
                    begin
                        acc_next    = '0;
                        acc_hi_next = 1'b0;
                        group_next  = '0;
                        if ((acc_sum == '0) && !hi_sum)
                        begin
                            phase_next = PH_TAG;
                        end
                        else
                        begin
                            // A length too wide for the skip counter saturates;
                            // the scan then simply runs into the last byte.
                            skip_next  = (hi_sum || (|acc_sum[ACC_W-1:SKIP_W])) ?
                                         '1 : acc_sum[SKIP_W-1:0];
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - SKIP_W'(1);
                    if (skip_reg == SKIP_W'(1))
                    begin
                        phase_next = PH_TAG;
                    end
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase
        end

        if (item.last_byte)
        begin
            if (!beat.valid && !decided_reg)
            begin
                beat.valid = 1'b1;
                beat.res   = '0;
            end
            phase_next       = PH_TAG;
            acc_next         = '0;
            acc_hi_next      = 1'b0;
            group_next       = '0;
            skip_next        = '0;
            byte_index_next  = '0;
            value_start_next = '0;
            start_byte_next  = '0;
            match_next       = 1'b0;
            decided_next     = 1'b0;
        end
        else if (byte_index_reg < IDX_LIMIT)
        begin
            byte_index_next = byte_index_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= WANTED_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            wanted_reg <= cfg.wanted_field;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TAG;
            acc_reg         <= '0;
            acc_hi_reg      <= 1'b0;
            group_reg       <= '0;
            skip_reg        <= '0;
            byte_index_reg  <= '0;
            value_start_reg <= '0;
            start_byte_reg  <= '0;
            match_reg       <= 1'b0;
            decided_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            acc_hi_reg      <= acc_hi_next;
            group_reg       <= group_next;
            skip_reg        <= skip_next;
            byte_index_reg  <= byte_index_next;
            value_start_reg <= value_start_next;
            start_byte_reg  <= start_byte_next;
            match_reg       <= match_next;
            decided_reg     <= decided_next;
        end
    end

    `PFL_ASSERT(a_found_in_value, advance && beat.valid && beat.res.found, phase_reg == PH_VALUE && match_reg, "found result outside a matching varint value")
    `PFL_ASSERT(a_miss_at_last, advance && beat.valid && !beat.res.found, item.last_byte, "miss result before the last byte")
    `PFL_ASSERT(a_quiet_when_decided, advance && decided_reg, !beat.valid, "second result for one buffer")
    `PFL_ASSERT_NEXT(a_clear_after_last, advance && item.last_byte, byte_index_reg == '0 && !decided_reg && phase_reg == PH_TAG, "buffer state not cleared after last byte")
endmodule

@@ rtl/pfl_out_stage.sv @@
// ----------------------------------------------------------------------------
// Field locator result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module pfl_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  pfl_pkg::result_beat_t beat,
    output logic                  free,
    pfl_result_if.source          results
);
    import pfl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign free       = !valid_reg || results.ready;
    assign load       = advance && beat.valid;
    assign valid_next = load ? 1'b1 : (results.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= beat.res;
        end
    end

    assign results.valid            = valid_reg;
    assign results.found            = res_reg.found;
    assign results.value_position   = res_reg.value_position;
    assign results.value_first_byte = res_reg.value_first_byte;
endmodule

@@ rtl/protobuf_top_field_locator_top.sv @@
// ----------------------------------------------------------------------------
// Protobuf top-level field locator
// Scans an encoded buffer one byte per beat and reports where the value of a
// wanted varint field starts, or a miss, once per buffer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle without gaps as long as results
// are taken: a byte is captured in the input register, and then the scanner
// updates its tag, length and skip state in a single step and, when a result
// is due, loads it into the output register, from which it is visible. The
// single-step scanner state update sets the rate of one byte per cycle while
// results are taken. While an untaken result sits in the output register,
// the byte in the input register waits and input ready drops once that
// register is also full. Each buffer gives exactly one result: at the last
// byte of a found varint value, or a miss at the buffer's last byte.
module protobuf_top_field_locator_top (
    input  logic         clk,
    input  logic         rst_n,
    pfl_byte_if.sink     bytes,
    pfl_cfg_if.sink      cfg,
    pfl_result_if.source results
);
    import pfl_pkg::*;

    logic         item_valid;
    item_t        item;
    logic         out_free;
    logic         advance;
    result_beat_t beat;

    assign advance = item_valid && out_free;

    pfl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pfl_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .beat    (beat)
    );

    pfl_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .beat    (beat),
        .free    (out_free),
        .results (results)
    );
endmodule
